// ===== rtl/core/page_slot_free_list_allocator_core_defines.svh =====
// ---------------------------------------------------------------------------
// page slot free list allocator - assertion macros
// shared property forms, clocked on aclk and disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef PAGE_SLOT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_SLOT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define PSFL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/psfl_pkg.sv =====
// ---------------------------------------------------------------------------
// psfl_pkg
// constants, codes, types and slot geometry helpers of the slot allocator
// ---------------------------------------------------------------------------
`default_nettype none

package psfl_pkg;

    // page geometry
    localparam int PAGE_BYTES       = 4096;
    localparam int HEADER_BYTES     = 16;
    localparam int MIN_OBJECT_BYTES = 16;

    // link memory
    localparam int LINK_DEPTH = 256;
    localparam int IDX_W      = $clog2(LINK_DEPTH);

    // field widths
    localparam int OFS_W  = 12;
    localparam int CNT_W  = 9;
    localparam int LG_W   = 4;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // wide enough for page size arithmetic
    localparam int CALC_W = 18;

    localparam int MAX_LOG2 = 11;
    localparam int MIN_LOG2 = ($clog2(MIN_OBJECT_BYTES) > MAX_LOG2) ? MAX_LOG2
                                                                    : $clog2(MIN_OBJECT_BYTES);
    localparam logic [LG_W-1:0] CFG_RESET_LOG2 = LG_W'(4);

    // stream widths
    localparam int S_TDATA_W = ((OFS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = OFS_W + STAT_W + CNT_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // commands
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]  free_slots;
        logic [STAT_W-1:0] status;
        logic [OFS_W-1:0]  slot_offset;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [OFS_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [LG_W-1:0] clamp_log2(input logic [LG_W-1:0] lg);
        logic [LG_W-1:0] r;
        r = lg;
        if (r < LG_W'(MIN_LOG2)) r = LG_W'(MIN_LOG2);
        if (r > LG_W'(MAX_LOG2)) r = LG_W'(MAX_LOG2);
        return r;
    endfunction

    // header rounded up to the slot size
    function automatic logic [CALC_W-1:0] first_slot(input logic [LG_W-1:0] lg);
        logic [CALC_W-1:0] size;
        size = CALC_W'(1) << lg;
        return (CALC_W'(HEADER_BYTES) + size - CALC_W'(1)) & ~(size - CALC_W'(1));
    endfunction

    function automatic logic [CNT_W-1:0] slot_total(input logic [LG_W-1:0] lg);
        logic [CALC_W-1:0] first;
        logic [CALC_W-1:0] n;
        first = first_slot(lg);
        if (first >= CALC_W'(PAGE_BYTES)) begin
            return '0;
        end
        n = (CALC_W'(PAGE_BYTES) - first) >> lg;
        if (n > CALC_W'(LINK_DEPTH)) begin
            return CNT_W'(LINK_DEPTH);
        end
        return n[CNT_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] link_index(input logic [OFS_W-1:0] ofs,
                                                    input logic [LG_W-1:0]  lg);
        logic [OFS_W-1:0] sh;
        sh = ofs >> lg;
        return sh[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/page_slot_free_list_allocator_core.sv =====
// ---------------------------------------------------------------------------
// page_slot_free_list_allocator_core
// lifo free list of fixed-size object slots in one page, links kept in ram
// ---------------------------------------------------------------------------
//
// channel   dir   handshake            payload
// s_        in    s_tvalid/s_tready    tuser: command, tdata: free_offset
// m_        out   m_tvalid/m_tready    tdata: slot_offset, status, free_slots
// cfg_      in    cfg_we               cfg_wdata: object_size_log2
//
// free, unknown commands and an empty alloc go from accept straight to the result
// state; an alloc with a free slot first waits for the registered link ram read;
// init preps, then fills one link per cycle through the single ram write port
// one item is in flight at a time; its result sits in the output register so
// the next item is accepted while it waits for m_tready
// aresetn clears the list (empty, count zero); the link ram is not cleared
//
`default_nettype none
`include "page_slot_free_list_allocator_core_defines.svh"

module page_slot_free_list_allocator_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config
    input  wire logic                              cfg_we,
    input  wire logic [psfl_pkg::LG_W-1:0]         cfg_wdata,   // object_size_log2
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [psfl_pkg::S_TDATA_W-1:0]    s_tdata,     // [11:0] free_offset
    input  wire logic [psfl_pkg::CMD_W-1:0]        s_tuser,     // [1:0] command
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [psfl_pkg::M_TDATA_W-1:0]         m_tdata      // [11:0] slot_offset,
                                                                // [13:12] status,
                                                                // [22:14] free_slots
);

    // slot size register, applied only by an init command
    logic [psfl_pkg::LG_W-1:0] cfg_log2_reg;

    // output register
    logic                  m_tvalid_reg;
    psfl_pkg::res_t        m_res_reg;

    psfl_pkg::mem_req_t        mem_req;
    logic [psfl_pkg::OFS_W-1:0] mem_rdata;
    logic                      res_valid;
    psfl_pkg::res_t            res;
    logic                      res_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_log2_reg <= psfl_pkg::CFG_RESET_LOG2;
        end else if (cfg_we) begin
            cfg_log2_reg <= cfg_wdata;
        end
    end

    psfl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_log2  (cfg_log2_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_ofs    (s_tdata[psfl_pkg::OFS_W-1:0]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // next-slot links, one entry per slot
    psfl_link_ram #(
        .DEPTH  (psfl_pkg::LINK_DEPTH),
        .DATA_W (psfl_pkg::OFS_W)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // result moves on when the output register is empty or draining
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(psfl_pkg::M_TDATA_W - psfl_pkg::M_FIELDS_W){1'b0}}, m_res_reg};

    // only one item in flight: ready drops right after an accept
    `PSFL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "item accepted while busy")

    // a failed or non-alloc result never carries a slot offset
    `PSFL_ASSERT_SAME(a_fail_no_slot, m_tvalid && (m_res_reg.status != psfl_pkg::STAT_OK), m_res_reg.slot_offset == '0, "failed result carries a slot offset")

    // free count stays within the link store
    `PSFL_ASSERT_SAME(a_count_range, m_tvalid, m_res_reg.free_slots <= psfl_pkg::CNT_W'(psfl_pkg::LINK_DEPTH), "free count beyond link store depth")

endmodule

`default_nettype wire

// ===== rtl/core/psfl_link_ram.sv =====
// ---------------------------------------------------------------------------
// psfl_link_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module psfl_link_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 12,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/psfl_ctrl.sv =====
// ---------------------------------------------------------------------------
// psfl_ctrl
// command sequencer: list head, free count, slot geometry and link updates
// ---------------------------------------------------------------------------
`default_nettype none

module psfl_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [psfl_pkg::LG_W-1:0]   cfg_log2,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [psfl_pkg::CMD_W-1:0]  in_cmd,
    input  wire logic [psfl_pkg::OFS_W-1:0]  in_ofs,
    output psfl_pkg::mem_req_t               mem_req,
    input  wire logic [psfl_pkg::OFS_W-1:0]  mem_rdata,
    output logic                             res_valid,
    output psfl_pkg::res_t                   res,
    input  wire logic                        res_take
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_RES    = 3'd4;

    localparam logic [psfl_pkg::LG_W-1:0] RST_LG = psfl_pkg::clamp_log2(psfl_pkg::CFG_RESET_LOG2);

    logic [2:0] state_reg, state_next;
    logic [psfl_pkg::LG_W-1:0]   lg_reg, lg_next;
    logic [psfl_pkg::CALC_W-1:0] first_reg, first_next;
    logic [psfl_pkg::CNT_W-1:0]  total_reg, total_next;
    logic [psfl_pkg::OFS_W-1:0]  head_reg, head_next;
    logic [psfl_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [psfl_pkg::OFS_W-1:0]  cur_reg, cur_next;
    logic [psfl_pkg::CNT_W-1:0]  fill_reg, fill_next;
    psfl_pkg::res_t              res_reg, res_next;

    logic [psfl_pkg::OFS_W-1:0]  size;
    logic [psfl_pkg::CALC_W-1:0] prep_first;
    logic [psfl_pkg::CNT_W-1:0]  prep_total;
    logic [psfl_pkg::CNT_W-1:0]  fill_inc;
    logic                        fill_last;
    logic                        free_ok;

    assign size       = psfl_pkg::OFS_W'(1) << lg_reg;
    assign prep_first = psfl_pkg::first_slot(lg_reg);
    assign prep_total = psfl_pkg::slot_total(lg_reg);
    assign fill_inc   = fill_reg + psfl_pkg::CNT_W'(1);
    assign fill_last  = (fill_inc == total_reg);

    // offset must be a slot start and the list must have room
    assign free_ok = ({{(psfl_pkg::CALC_W - psfl_pkg::OFS_W){1'b0}}, in_ofs} >= first_reg)
                  && ({{(psfl_pkg::CALC_W - psfl_pkg::OFS_W){1'b0}}, in_ofs}
                      < psfl_pkg::CALC_W'(psfl_pkg::PAGE_BYTES))
                  && ((in_ofs & (size - psfl_pkg::OFS_W'(1))) == '0)
                  && (count_reg < total_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RES);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        lg_next    = lg_reg;
        first_next = first_reg;
        total_next = total_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        fill_next  = fill_reg;
        res_next   = res_reg;
        mem_req    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    res_next = '{free_slots: count_reg, status: psfl_pkg::STAT_OK,
                                 slot_offset: '0};
                    state_next = ST_RES;
                    unique case (in_cmd)
                        psfl_pkg::CMD_INIT: begin
                            lg_next    = psfl_pkg::clamp_log2(cfg_log2);
                            state_next = ST_PREP;
                        end
                        psfl_pkg::CMD_ALLOC: begin
                            if (count_reg == '0) begin
                                res_next.status = psfl_pkg::STAT_EMPTY;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = psfl_pkg::link_index(head_reg, lg_reg);
                                state_next    = ST_RDWAIT;
                            end
                        end
                        psfl_pkg::CMD_FREE: begin
                            if (free_ok) begin
                                mem_req.we          = 1'b1;
                                mem_req.waddr       = psfl_pkg::link_index(in_ofs, lg_reg);
                                mem_req.wdata       = head_reg;
                                head_next           = in_ofs;
                                count_next          = count_reg + psfl_pkg::CNT_W'(1);
                                res_next.free_slots = count_reg + psfl_pkg::CNT_W'(1);
                            end else begin
                                res_next.status = psfl_pkg::STAT_BAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PREP: begin
                first_next = prep_first;
                total_next = prep_total;
                cur_next   = prep_first[psfl_pkg::OFS_W-1:0];
                fill_next  = '0;
                if (prep_total == '0) begin
                    head_next  = '0;
                    count_next = '0;
                    res_next   = '{free_slots: '0, status: psfl_pkg::STAT_OK, slot_offset: '0};
                    state_next = ST_RES;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                // one link per cycle, ascending, last slot terminates with zero
                mem_req.we    = 1'b1;
                mem_req.waddr = psfl_pkg::link_index(cur_reg, lg_reg);
                mem_req.wdata = fill_last ? '0 : cur_reg + size;
                cur_next      = cur_reg + size;
                fill_next     = fill_inc;
                if (fill_last) begin
                    head_next  = first_reg[psfl_pkg::OFS_W-1:0];
                    count_next = total_reg;
                    res_next   = '{free_slots: total_reg, status: psfl_pkg::STAT_OK,
                                   slot_offset: '0};
                    state_next = ST_RES;
                end
            end
            ST_RDWAIT: begin
                head_next  = mem_rdata;
                count_next = count_reg - psfl_pkg::CNT_W'(1);
                res_next   = '{free_slots: count_reg - psfl_pkg::CNT_W'(1),
                               status: psfl_pkg::STAT_OK, slot_offset: head_reg};
                state_next = ST_RES;
            end
            ST_RES: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lg_reg    <= RST_LG;
            first_reg <= psfl_pkg::first_slot(RST_LG);
            total_reg <= psfl_pkg::slot_total(RST_LG);
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            lg_reg    <= lg_next;
            first_reg <= first_next;
            total_reg <= total_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        fill_reg <= fill_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire
